// ===== rtl/itf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the integer-to-text formatter.
// No dependencies; every other file imports this package.
package itf_pkg;

  // Field widths fixed by the item format
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned FIELD_W = 6;
  localparam int unsigned RADIX_W = 2;
  localparam int unsigned CHAR_W  = 8;

  // Default cap on the field size in characters
  localparam int unsigned ITF_MAX_FIELD = 63;

  // Digit store: enough digits for 64 bits in octal
  localparam int unsigned NUM_DIGITS = 22;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned ND_W       = $clog2(NUM_DIGITS + 1);
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);

  // Binary-to-BCD conversion: bits consumed per cycle and number of conversion steps
  localparam int unsigned DABBLE_BITS = 4;
  localparam int unsigned CONV_STEPS  = VALUE_W / DABBLE_BITS;
  localparam int unsigned CONV_CNT_W  = $clog2(CONV_STEPS);

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Radix codes; the unused code is treated as hex
  localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd0;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 2'd1;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd2;

  // ASCII characters
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_MINUS,
    SIGN_PLUS,
    SIGN_SPACE
  } itf_sign_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } itf_state_t;

  typedef logic [DIGIT_W-1:0] itf_digit_t;

  // One classified item as it travels from front to back
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    itf_sign_t          sign;
    logic [RADIX_W-1:0] radix;
    logic               upper;
    logic               left;
    logic               zpad;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] prec;
  } itf_job_t;

  // Map one digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input itf_digit_t d, input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + ext;
    end else if (upper) begin
      digit_char = CH_UPPER_A + ext - 8'd10;
    end else begin
      digit_char = CH_LOWER_A + ext - 8'd10;
    end
  endfunction

  // Map a sign code to its ASCII character
  function automatic logic [CHAR_W-1:0] sign_char(input itf_sign_t s);
    unique case (s)
      SIGN_MINUS: sign_char = CH_MINUS;
      SIGN_PLUS:  sign_char = CH_PLUS;
      default:    sign_char = CH_SPACE;
    endcase
  endfunction

endpackage

// ===== rtl/itf_intf.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the formatter's input and result words.
// Depends on itf_pkg for field widths.
interface itf_in_if import itf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               is_signed;
  logic [RADIX_W-1:0] radix;
  logic               upper_case;
  logic               left_justify;
  logic               force_plus;
  logic               space_sign;
  logic               zero_pad;
  logic [FIELD_W-1:0] min_width;
  logic [FIELD_W-1:0] precision;

  modport source(output valid, value, is_signed, radix, upper_case, left_justify,
                 force_plus, space_sign, zero_pad, min_width, precision,
                 input ready);
  modport sink(input valid, value, is_signed, radix, upper_case, left_justify,
               force_plus, space_sign, zero_pad, min_width, precision,
               output ready);
endinterface

interface itf_out_if import itf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source(output valid, out_char, last, input ready);
  modport sink(input valid, out_char, last, output ready);
endinterface

// ===== rtl/itf_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input words, works out sign and magnitude, clamps width/precision.
// Depends on itf_pkg and itf_in_if; feeds itf_queue.
module itf_front import itf_pkg::*; #(
  parameter int unsigned MAX_FIELD = ITF_MAX_FIELD
) (
  itf_in_if.sink   in_ch,
  output logic     push_valid,
  input  logic     push_ready,
  output itf_job_t push_job
);

  localparam logic [FIELD_W-1:0] WIDTH_CAP = FIELD_W'(MAX_FIELD);
  localparam logic [FIELD_W-1:0] PREC_CAP  = FIELD_W'(MAX_FIELD - 1);

  // Pass the handshake through to the queue
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  // Classify sign and take the magnitude
  always_comb begin
    push_job.mag  = in_ch.value;
    push_job.sign = SIGN_NONE;
    if (in_ch.is_signed) begin
      if (in_ch.value[VALUE_W-1]) begin
        push_job.sign = SIGN_MINUS;
        push_job.mag  = {VALUE_W{1'b0}} - in_ch.value;
      end else if (in_ch.force_plus) begin
        push_job.sign = SIGN_PLUS;
      end else if (in_ch.space_sign) begin
        push_job.sign = SIGN_SPACE;
      end
    end
    push_job.radix = in_ch.radix;
    push_job.upper = in_ch.upper_case;
    push_job.left  = in_ch.left_justify;
    push_job.zpad  = in_ch.zero_pad;
    push_job.width = (in_ch.min_width > WIDTH_CAP) ? WIDTH_CAP : in_ch.min_width;
    push_job.prec  = (in_ch.precision > PREC_CAP) ? PREC_CAP : in_ch.precision;
  end

endmodule

// ===== rtl/itf_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified items between the front end and the back end.
// Depends on itf_pkg for the item type and depth.
module itf_queue import itf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  itf_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output itf_job_t pop_job
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  itf_job_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_go, pop_go;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push_go    = push_valid && push_ready;
  assign pop_go     = pop_valid && pop_ready;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_go) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_go) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_go && !pop_go) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_go && !push_go) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push_go) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/itf_back.sv =====
`timescale 1ns / 1ps
// Back end: digit extraction (BCD conversion or bit slicing), layout and character output.
// Depends on itf_pkg and itf_out_if; pulls items from itf_queue.
module itf_back import itf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  itf_job_t pop_job,
  itf_out_if.source out_ch
);

  itf_state_t            state_r, state_nxt;
  itf_digit_t            digs_r [NUM_DIGITS];
  itf_digit_t            digs_nxt [NUM_DIGITS];
  logic [VALUE_W-1:0]    shf_r, shf_nxt;
  logic [CONV_CNT_W-1:0] cnt_r, cnt_nxt;
  itf_sign_t             sign_r, sign_nxt;
  logic                  upper_r, upper_nxt;
  logic                  left_r, left_nxt;
  logic                  zpad_r, zpad_nxt;
  logic [FIELD_W-1:0]    width_r, width_nxt;
  logic [FIELD_W-1:0]    prec_r, prec_nxt;
  logic [FIELD_W-1:0]    lead_r, lead_nxt;
  logic                  sgn_pend_r, sgn_pend_nxt;
  logic [FIELD_W-1:0]    zero_r, zero_nxt;
  logic [ND_W-1:0]       dig_r, dig_nxt;
  logic [FIELD_W-1:0]    tail_r, tail_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  conv_done;
  logic                  emit_go;
  logic                  load_dec;
  itf_digit_t            load_digs [NUM_DIGITS];
  itf_digit_t            dab_digs [NUM_DIGITS];
  logic [VALUE_W-1:0]    dab_shf;
  logic [ND_W-1:0]       nd_c;
  logic [FIELD_W-1:0]    sz_lead, sz_zero, sz_tail;
  logic [CHAR_W-1:0]     em_char;
  logic                  em_last;
  logic [FIELD_W-1:0]    em_lead, em_zero, em_tail;
  logic                  em_sgn;
  logic [ND_W-1:0]       em_dig;

  assign conv_done = (cnt_r == CONV_CNT_W'(CONV_STEPS - 1));
  assign load_dec  = (pop_job.radix == RADIX_DEC);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          state_nxt = load_dec ? ST_CONV : ST_SIZE;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go && em_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: pull from the queue when idle, emit when the output slot frees up
  always_comb begin
    pop_ready = 1'b0;
    emit_go   = 1'b0;
    unique case (state_r)
      ST_IDLE: pop_ready = 1'b1;
      ST_EMIT: emit_go   = !out_valid_r || out_ch.ready;
      default: begin
        pop_ready = 1'b0;
        emit_go   = 1'b0;
      end
    endcase
  end

  // Slice octal or hex digits straight from the magnitude; decimal starts from zero
  always_comb begin
    logic [3*NUM_DIGITS-1:0] oct_pad;
    logic [4*NUM_DIGITS-1:0] hex_pad;
    oct_pad = {{(3*NUM_DIGITS - VALUE_W){1'b0}}, pop_job.mag};
    hex_pad = {{(4*NUM_DIGITS - VALUE_W){1'b0}}, pop_job.mag};
    for (int i = 0; i < NUM_DIGITS; i++) begin
      unique case (pop_job.radix)
        RADIX_DEC: load_digs[i] = '0;
        RADIX_OCT: load_digs[i] = {1'b0, oct_pad[3*i +: 3]};
        default:   load_digs[i] = hex_pad[4*i +: 4];
      endcase
    end
  end

  // Double-dabble: add 3 to digits of 5 or more, then shift in one bit; four bits a cycle
  always_comb begin
    itf_digit_t         d [NUM_DIGITS];
    logic [VALUE_W-1:0] s;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      d[j] = digs_r[j];
    end
    s = shf_r;
    for (int k = 0; k < DABBLE_BITS; k++) begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
        if (d[j] >= 4'd5) begin
          d[j] = d[j] + 4'd3;
        end
      end
      for (int j = NUM_DIGITS - 1; j > 0; j--) begin
        d[j] = {d[j][DIGIT_W-2:0], d[j-1][DIGIT_W-1]};
      end
      d[0] = {d[0][DIGIT_W-2:0], s[VALUE_W-1]};
      s    = {s[VALUE_W-2:0], 1'b0};
    end
    for (int j = 0; j < NUM_DIGITS; j++) begin
      dab_digs[j] = d[j];
    end
    dab_shf = s;
  end

  // Lay out the field: digit count, zero fill and space padding
  always_comb begin
    logic [FIELD_W-1:0] nd6;
    logic [FIELD_W-1:0] body;
    logic [FIELD_W-1:0] zl;
    logic [FIELD_W:0]   used;
    logic [FIELD_W-1:0] sl;
    nd_c = ND_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (digs_r[i] != '0) begin
        nd_c = ND_W'(i + 1);
      end
    end
    nd6  = FIELD_W'(nd_c);
    body = (prec_r > nd6) ? prec_r : nd6;
    zl   = (prec_r > nd6) ? prec_r - nd6 : '0;
    used = {1'b0, body} + (FIELD_W + 1)'(sign_r != SIGN_NONE);
    sl   = ({1'b0, width_r} > used) ? FIELD_W'({1'b0, width_r} - used) : '0;
    if (zpad_r) begin
      sz_zero = (sl > zl) ? sl : zl;
      sz_lead = '0;
      sz_tail = '0;
    end else begin
      sz_zero = zl;
      sz_lead = left_r ? '0 : sl;
      sz_tail = left_r ? sl : '0;
    end
  end

  // Pick the next character: lead spaces, sign, zeros, digits, trailing spaces
  always_comb begin
    logic [IDX_W-1:0] idx;
    idx     = IDX_W'(dig_r - 1'b1);
    em_lead = lead_r;
    em_sgn  = sgn_pend_r;
    em_zero = zero_r;
    em_dig  = dig_r;
    em_tail = tail_r;
    if (lead_r != '0) begin
      em_char = CH_SPACE;
      em_lead = lead_r - 1'b1;
    end else if (sgn_pend_r) begin
      em_char = sign_char(sign_r);
      em_sgn  = 1'b0;
    end else if (zero_r != '0) begin
      em_char = CH_ZERO;
      em_zero = zero_r - 1'b1;
    end else if (dig_r != '0) begin
      em_char = digit_char(digs_r[idx], upper_r);
      em_dig  = dig_r - 1'b1;
    end else begin
      em_char = CH_SPACE;
      em_tail = tail_r - 1'b1;
    end
    em_last = (em_lead == '0) && !em_sgn && (em_zero == '0) && (em_dig == '0) &&
              (em_tail == '0);
  end

  // Register updates by state
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digs_nxt[i] = digs_r[i];
    end
    shf_nxt       = shf_r;
    cnt_nxt       = cnt_r;
    sign_nxt      = sign_r;
    upper_nxt     = upper_r;
    left_nxt      = left_r;
    zpad_nxt      = zpad_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    lead_nxt      = lead_r;
    sgn_pend_nxt  = sgn_pend_r;
    zero_nxt      = zero_r;
    dig_nxt       = dig_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            digs_nxt[i] = load_digs[i];
          end
          shf_nxt   = pop_job.mag;
          cnt_nxt   = '0;
          sign_nxt  = pop_job.sign;
          upper_nxt = pop_job.upper;
          left_nxt  = pop_job.left;
          zpad_nxt  = pop_job.zpad;
          width_nxt = pop_job.width;
          prec_nxt  = pop_job.prec;
        end
      end
      ST_CONV: begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          digs_nxt[i] = dab_digs[i];
        end
        shf_nxt = dab_shf;
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_SIZE: begin
        lead_nxt     = sz_lead;
        sgn_pend_nxt = (sign_r != SIGN_NONE);
        zero_nxt     = sz_zero;
        dig_nxt      = nd_c;
        tail_nxt     = sz_tail;
      end
      ST_EMIT: begin
        if (emit_go) begin
          lead_nxt      = em_lead;
          sgn_pend_nxt  = em_sgn;
          zero_nxt      = em_zero;
          dig_nxt       = em_dig;
          tail_nxt      = em_tail;
          out_valid_nxt = 1'b1;
          out_char_nxt  = em_char;
          out_last_nxt  = em_last;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digs_r[i] <= digs_nxt[i];
    end
    shf_r      <= shf_nxt;
    cnt_r      <= cnt_nxt;
    sign_r     <= sign_nxt;
    upper_r    <= upper_nxt;
    left_r     <= left_nxt;
    zpad_r     <= zpad_nxt;
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    lead_r     <= lead_nxt;
    sgn_pend_r <= sgn_pend_nxt;
    zero_r     <= zero_nxt;
    dig_r      <= dig_nxt;
    tail_r     <= tail_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;

endmodule

// ===== rtl/integer_to_text_formatter.sv =====
`timescale 1ns / 1ps
// Integer-to-text formatter, printf-style integer conversion.
//
// Input channel in_ch: one word carries a 64-bit value and its options
// (signedness, radix, case, justification, sign flags, zero pad, width,
// precision). Result channel out_ch: one ASCII character per word, the
// final character of an item marked by last. Both use valid/ready.
//
// The front end classifies each word and parks it in a two-entry queue, so
// words are taken while the back end is still busy. The back end works on
// one item at a time: it takes the item, runs BCD conversion (four bits a
// cycle) for decimal only, lays out the field, then sends one character a
// cycle while the receiver is ready, and takes the next item after the last.
//
// Reset (rst_n low, synchronous) empties the queue and the output register.
// A stalled receiver holds the current character; the back end then waits,
// and the front end keeps accepting until the queue is full.
//
module integer_to_text_formatter import itf_pkg::*; #(
  parameter int unsigned MAX_FIELD = ITF_MAX_FIELD
) (
  input  logic       clk,
  input  logic       rst_n,
  itf_in_if.sink     in_ch,
  itf_out_if.source  out_ch
);

  logic     push_valid, push_ready;
  itf_job_t push_job;
  logic     pop_valid, pop_ready;
  itf_job_t pop_job;

  itf_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .in_ch     (in_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  itf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  itf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job  (pop_job),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/itf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the integer-to-text formatter, bound to the top level.
// Depends on itf_pkg and integer_to_text_formatter.
module itf_checker import itf_pkg::*; #(
  parameter int unsigned MAX_FIELD = ITF_MAX_FIELD
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  logic       in_acc, out_acc, done_acc;
  logic [2:0] pend_r, pend_nxt;
  logic [5:0] chars_r, chars_nxt;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign done_acc = out_acc && out_last;

  // Track items in flight and characters of the current item
  always_comb begin
    pend_nxt  = pend_r + 3'(in_acc) - 3'(done_acc);
    chars_nxt = chars_r;
    if (done_acc) begin
      chars_nxt = '0;
    end else if (out_acc) begin
      chars_nxt = chars_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      chars_r <= '0;
    end else begin
      pend_r  <= pend_nxt;
      chars_r <= chars_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled word changed");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("character without a pending item");

  a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_last |-> chars_r < 6'(MAX_FIELD - 1))
    else $error("item longer than the field limit");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= CH_ZERO && out_char <= CH_ZERO + 8'd9) ||
                  (out_char >= CH_UPPER_A && out_char <= CH_UPPER_A + 8'd5) ||
                  (out_char >= CH_LOWER_A && out_char <= CH_LOWER_A + 8'd5) ||
                  out_char == CH_SPACE || out_char == CH_PLUS || out_char == CH_MINUS)
    else $error("character outside the output alphabet");

endmodule

bind integer_to_text_formatter itf_checker #(
  .MAX_FIELD(MAX_FIELD)
) u_itf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_char (out_ch.out_char),
  .out_last (out_ch.last)
);
